// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the overlap-test RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define SPOT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spot assertion failed");

// Check that cons holds in the cycle after ante, outside reset.
`define SPOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spot assertion failed");

`endif

// ===== rtl/core/spot_pkg.sv =====
// Shared widths, flag positions and stage types for the shape-pair overlap test.
`timescale 1ns / 1ps

package spot_pkg;

  localparam int TAG_W   = 16;
  localparam int FLAG_W  = 4;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int MAG_W   = 16;
  localparam int SQ_W    = 2 * MAG_W;

  localparam int FLAG_FIRST_BOX     = 0;
  localparam int FLAG_FIRST_CIRCLE  = 1;
  localparam int FLAG_SECOND_BOX    = 2;
  localparam int FLAG_SECOND_CIRCLE = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;

  // Control that rides along with each beat.
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [FLAG_W-1:0] flags;
  } ctl_t;

  typedef struct packed {
    size_t aw;
    size_t ah;
    size_t ar;
    size_t bw;
    size_t bh;
    size_t br;
  } sizes_t;

  // Box hit, center separation, outside-distance of the other center from each box per axis, and radii.
  typedef struct packed {
    logic  box_hit;
    mag_t  adx;
    mag_t  ady;
    mag_t  e1x;
    mag_t  e1y;
    mag_t  e2x;
    mag_t  e2y;
    mag_t  rsum;
    size_t ar;
    size_t br;
  } edge_t;

  typedef struct packed {
    logic box_hit;
    sq_t  dx2;
    sq_t  dy2;
    sq_t  e1x2;
    sq_t  e1y2;
    sq_t  e2x2;
    sq_t  e2y2;
    sq_t  rsum2;
    sq_t  ar2;
    sq_t  br2;
  } square_t;

endpackage

// ===== rtl/core/spot_delta.sv =====
// Stage 1: absolute center separation per axis.
`timescale 1ns / 1ps

module spot_delta (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spot_pkg::ctl_t         ctl_in,
  input  spot_pkg::coord_t       first_x,
  input  spot_pkg::coord_t       first_y,
  input  spot_pkg::coord_t       second_x,
  input  spot_pkg::coord_t       second_y,
  input  spot_pkg::sizes_t       sizes_in,
  output spot_pkg::ctl_t         ctl_r,
  output spot_pkg::mag_t         adx_r,
  output spot_pkg::mag_t         ady_r,
  output spot_pkg::sizes_t       sizes_r
);

  logic signed [spot_pkg::COORD_W:0] dx;
  logic signed [spot_pkg::COORD_W:0] dy;
  logic signed [spot_pkg::COORD_W:0] adx_full;
  logic signed [spot_pkg::COORD_W:0] ady_full;
  spot_pkg::mag_t                    adx_nxt;
  spot_pkg::mag_t                    ady_nxt;

  always_comb begin
    dx       = {first_x[spot_pkg::COORD_W-1], first_x} - {second_x[spot_pkg::COORD_W-1], second_x};
    dy       = {first_y[spot_pkg::COORD_W-1], first_y} - {second_y[spot_pkg::COORD_W-1], second_y};
    adx_full = dx[spot_pkg::COORD_W] ? -dx : dx;
    ady_full = dy[spot_pkg::COORD_W] ? -dy : dy;
    // magnitude never exceeds 65535, so the sign bit drops out
    adx_nxt  = adx_full[spot_pkg::MAG_W-1:0];
    ady_nxt  = ady_full[spot_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.tag   <= ctl_in.tag;
    ctl_r.flags <= ctl_in.flags;
    adx_r       <= adx_nxt;
    ady_r       <= ady_nxt;
    sizes_r     <= sizes_in;
  end

endmodule

// ===== rtl/core/spot_edge.sv =====
// Stage 2: box-box compare and distances from each box edge to the other center.
`timescale 1ns / 1ps

module spot_edge (
  input  logic             clk,
  input  logic             rst_n,
  input  spot_pkg::ctl_t   ctl_in,
  input  spot_pkg::mag_t   adx,
  input  spot_pkg::mag_t   ady,
  input  spot_pkg::sizes_t sizes,
  output spot_pkg::ctl_t   ctl_r,
  output spot_pkg::edge_t  edge_r
);

  spot_pkg::edge_t edge_nxt;
  spot_pkg::mag_t  wsum;
  spot_pkg::mag_t  hsum;

  // Clear to zero when the center lies inside the half extent.
  function automatic spot_pkg::mag_t outside(spot_pkg::mag_t d, spot_pkg::size_t half);
    spot_pkg::mag_t h;
    h = {1'b0, half};
    return (d > h) ? d - h : '0;
  endfunction

  always_comb begin
    wsum              = {1'b0, sizes.aw} + {1'b0, sizes.bw};
    hsum              = {1'b0, sizes.ah} + {1'b0, sizes.bh};
    edge_nxt.box_hit  = (adx <= wsum) && (ady <= hsum);
    edge_nxt.adx      = adx;
    edge_nxt.ady      = ady;
    edge_nxt.e1x      = outside(adx, sizes.aw);
    edge_nxt.e1y      = outside(ady, sizes.ah);
    edge_nxt.e2x      = outside(adx, sizes.bw);
    edge_nxt.e2y      = outside(ady, sizes.bh);
    edge_nxt.rsum     = {1'b0, sizes.ar} + {1'b0, sizes.br};
    edge_nxt.ar       = sizes.ar;
    edge_nxt.br       = sizes.br;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.tag   <= ctl_in.tag;
    ctl_r.flags <= ctl_in.flags;
    edge_r      <= edge_nxt;
  end

endmodule

// ===== rtl/core/spot_square.sv =====
// Stage 3: squares of all distances and radii, one 16x16 multiplier each.
`timescale 1ns / 1ps

module spot_square (
  input  logic              clk,
  input  logic              rst_n,
  input  spot_pkg::ctl_t    ctl_in,
  input  spot_pkg::edge_t   edge_in,
  output spot_pkg::ctl_t    ctl_r,
  output spot_pkg::square_t sq_r
);

  spot_pkg::square_t sq_nxt;
  spot_pkg::mag_t    ar_m;
  spot_pkg::mag_t    br_m;

  function automatic spot_pkg::sq_t sqr(spot_pkg::mag_t v);
    return spot_pkg::sq_t'(v) * spot_pkg::sq_t'(v);
  endfunction

  always_comb begin
    ar_m           = {1'b0, edge_in.ar};
    br_m           = {1'b0, edge_in.br};
    sq_nxt.box_hit = edge_in.box_hit;
    sq_nxt.dx2     = sqr(edge_in.adx);
    sq_nxt.dy2     = sqr(edge_in.ady);
    sq_nxt.e1x2    = sqr(edge_in.e1x);
    sq_nxt.e1y2    = sqr(edge_in.e1y);
    sq_nxt.e2x2    = sqr(edge_in.e2x);
    sq_nxt.e2y2    = sqr(edge_in.e2y);
    sq_nxt.rsum2   = sqr(edge_in.rsum);
    sq_nxt.ar2     = sqr(ar_m);
    sq_nxt.br2     = sqr(br_m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.tag   <= ctl_in.tag;
    ctl_r.flags <= ctl_in.flags;
    sq_r        <= sq_nxt;
  end

endmodule

// ===== rtl/core/spot_decide.sv =====
// Stage 4: squared-distance compares, flag gating and the result register.
`timescale 1ns / 1ps

module spot_decide (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spot_pkg::ctl_t                ctl_in,
  input  spot_pkg::square_t             sq,
  output logic                          out_valid_r,
  output logic [spot_pkg::TAG_W-1:0]    out_tag_r,
  output logic                          out_overlap_r
);

  logic [spot_pkg::SQ_W:0] d2_cc;
  logic [spot_pkg::SQ_W:0] d2_fb;
  logic [spot_pkg::SQ_W:0] d2_sb;
  logic                    fb;
  logic                    fc;
  logic                    sb;
  logic                    sc;
  logic                    overlap_nxt;

  always_comb begin
    fb    = ctl_in.flags[spot_pkg::FLAG_FIRST_BOX];
    fc    = ctl_in.flags[spot_pkg::FLAG_FIRST_CIRCLE];
    sb    = ctl_in.flags[spot_pkg::FLAG_SECOND_BOX];
    sc    = ctl_in.flags[spot_pkg::FLAG_SECOND_CIRCLE];
    d2_cc = {1'b0, sq.dx2} + {1'b0, sq.dy2};
    d2_fb = {1'b0, sq.e1x2} + {1'b0, sq.e1y2};
    d2_sb = {1'b0, sq.e2x2} + {1'b0, sq.e2y2};
    overlap_nxt = (fb && sb && sq.box_hit)
               || (fb && sc && (d2_fb <= {1'b0, sq.br2}))
               || (fc && sb && (d2_sb <= {1'b0, sq.ar2}))
               || (fc && sc && (d2_cc <= {1'b0, sq.rsum2}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tag_r     <= ctl_in.tag;
    out_overlap_r <= overlap_nxt;
  end

endmodule

// ===== rtl/core/shape_pair_overlap_test.sv =====
// Top level of the 2D box/circle pair overlap test.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Overlap test for one pair of 2D shapes per beat. Raise start with the pair's
// fields; busy is always low, so a new pair may enter on every clock. The result
// appears on out_pair_tag_out and out_overlap with out_valid high for exactly one
// cycle, after the registered stages separation, edge distances, squaring and
// compare, in input order. The receiver cannot stall the block; it must take
// each result in the cycle it is shown. Touching shapes count as overlapping,
// and a pair with no applicable shape combination reports zero.
module shape_pair_overlap_test (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [spot_pkg::TAG_W-1:0]      in_pair_tag,
  input  logic [spot_pkg::FLAG_W-1:0]     in_shape_flags,
  input  logic signed [spot_pkg::COORD_W-1:0] in_first_x,
  input  logic signed [spot_pkg::COORD_W-1:0] in_first_y,
  input  logic [spot_pkg::SIZE_W-1:0]     in_first_half_w,
  input  logic [spot_pkg::SIZE_W-1:0]     in_first_half_h,
  input  logic [spot_pkg::SIZE_W-1:0]     in_first_radius,
  input  logic signed [spot_pkg::COORD_W-1:0] in_second_x,
  input  logic signed [spot_pkg::COORD_W-1:0] in_second_y,
  input  logic [spot_pkg::SIZE_W-1:0]     in_second_half_w,
  input  logic [spot_pkg::SIZE_W-1:0]     in_second_half_h,
  input  logic [spot_pkg::SIZE_W-1:0]     in_second_radius,
  output logic                            out_valid,
  output logic [spot_pkg::TAG_W-1:0]      out_pair_tag_out,
  output logic                            out_overlap
);

  spot_pkg::ctl_t    ctl_in;
  spot_pkg::sizes_t  sizes_in;
  spot_pkg::ctl_t    ctl1;
  spot_pkg::ctl_t    ctl2;
  spot_pkg::ctl_t    ctl3;
  spot_pkg::mag_t    adx1;
  spot_pkg::mag_t    ady1;
  spot_pkg::sizes_t  sizes1;
  spot_pkg::edge_t   edge2;
  spot_pkg::square_t sq3;

  assign busy = 1'b0;

  always_comb begin
    ctl_in.valid = start && !busy;
    ctl_in.tag   = in_pair_tag;
    ctl_in.flags = in_shape_flags;
    sizes_in.aw  = in_first_half_w;
    sizes_in.ah  = in_first_half_h;
    sizes_in.ar  = in_first_radius;
    sizes_in.bw  = in_second_half_w;
    sizes_in.bh  = in_second_half_h;
    sizes_in.br  = in_second_radius;
  end

  spot_delta u_delta (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl_in),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .sizes_in (sizes_in),
    .ctl_r    (ctl1),
    .adx_r    (adx1),
    .ady_r    (ady1),
    .sizes_r  (sizes1)
  );

  spot_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (ctl1),
    .adx    (adx1),
    .ady    (ady1),
    .sizes  (sizes1),
    .ctl_r  (ctl2),
    .edge_r (edge2)
  );

  spot_square u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl2),
    .edge_in (edge2),
    .ctl_r   (ctl3),
    .sq_r    (sq3)
  );

  spot_decide u_decide (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_in        (ctl3),
    .sq            (sq3),
    .out_valid_r   (out_valid),
    .out_tag_r     (out_pair_tag_out),
    .out_overlap_r (out_overlap)
  );

  // A result only follows a beat that was taken with start high.
  `SPOT_ASSERT_IMP(a_out_follows_start, out_valid, $past(start, 4))
  // The tag comes out with the beat it went in with.
  `SPOT_ASSERT_IMP(a_tag_echo, out_valid, out_pair_tag_out == $past(in_pair_tag, 4))
  // Contact needs at least one shape on each side.
  `SPOT_ASSERT_IMP(a_overlap_needs_shapes, out_valid && out_overlap,
    ($past(in_shape_flags[spot_pkg::FLAG_FIRST_BOX], 4) ||
     $past(in_shape_flags[spot_pkg::FLAG_FIRST_CIRCLE], 4)) &&
    ($past(in_shape_flags[spot_pkg::FLAG_SECOND_BOX], 4) ||
     $past(in_shape_flags[spot_pkg::FLAG_SECOND_CIRCLE], 4)))

endmodule
